FILE: sv/dstl_pkg.sv
// Shared types, constants and helpers for the deadline-sorted timer list.
package dstl_pkg;

  // Pool size and field widths.
  localparam int SLOT_COUNT = 32;
  localparam int TIME_BITS  = 32;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int LINK_W     = $clog2(SLOT_COUNT + 1);
  localparam int CMD_W      = 2;
  localparam int KIND_W     = 2;
  localparam int NUM_W      = 5;
  localparam int STATUS_W   = 3;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [LINK_W-1:0]    link_t;
  typedef logic [TIME_BITS-1:0] stamp_t;
  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [NUM_W-1:0]     num_t;

  // A link equal to the slot count marks the end of a chain.
  localparam link_t NIL = link_t'(SLOT_COUNT);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_EXPIRED   = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NONE_DUE  = 3'd3,
    ST_POOL_FULL = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  // Write port of one link memory.
  typedef struct packed {
    logic  we;
    idx_t  addr;
    link_t data;
  } link_wr_t;

  // Write port of the slot payload memory.
  typedef struct packed {
    logic   we;
    idx_t   addr;
    kind_t  kind;
    num_t   number;
    stamp_t due;
  } data_wr_t;

  // Registered read of one slot.
  typedef struct packed {
    link_t  next;
    link_t  prev;
    kind_t  kind;
    num_t   number;
    stamp_t due;
  } slot_rd_t;

  // True when a link points at a real slot.
  function automatic logic link_ok(link_t l);
    return l < NIL;
  endfunction

endpackage

FILE: sv/dstl_mem.sv
// Slot storage: next links, previous links and slot payload, all read at
// one shared address with a registered read port.
module dstl_mem (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  dstl_pkg::idx_t     rd_addr,
  input  dstl_pkg::link_wr_t next_wr,
  input  dstl_pkg::link_wr_t prev_wr,
  input  dstl_pkg::data_wr_t data_wr,
  output dstl_pkg::slot_rd_t rd
);

  dstl_pkg::link_t  next_mem   [dstl_pkg::SLOT_COUNT];
  dstl_pkg::link_t  prev_mem   [dstl_pkg::SLOT_COUNT];
  dstl_pkg::kind_t  kind_mem   [dstl_pkg::SLOT_COUNT];
  dstl_pkg::num_t   number_mem [dstl_pkg::SLOT_COUNT];
  dstl_pkg::stamp_t due_mem    [dstl_pkg::SLOT_COUNT];

  // One bit per slot tells whether its next link was ever written.
  logic [dstl_pkg::SLOT_COUNT-1:0] next_vld;

  dstl_pkg::link_t  next_q;
  dstl_pkg::link_t  prev_q;
  dstl_pkg::kind_t  kind_q;
  dstl_pkg::num_t   number_q;
  dstl_pkg::stamp_t due_q;
  dstl_pkg::idx_t   addr_q;
  logic             vld_q;

  // Writes, and reads that hold their data until the next read.
  always_ff @(posedge clk) begin
    if (next_wr.we) begin
      next_mem[next_wr.addr] <= next_wr.data;
    end
    if (prev_wr.we) begin
      prev_mem[prev_wr.addr] <= prev_wr.data;
    end
    if (data_wr.we) begin
      kind_mem[data_wr.addr]   <= data_wr.kind;
      number_mem[data_wr.addr] <= data_wr.number;
      due_mem[data_wr.addr]    <= data_wr.due;
    end
    if (rd_en) begin
      next_q   <= next_mem[rd_addr];
      prev_q   <= prev_mem[rd_addr];
      kind_q   <= kind_mem[rd_addr];
      number_q <= number_mem[rd_addr];
      due_q    <= due_mem[rd_addr];
      addr_q   <= rd_addr;
      vld_q    <= next_vld[rd_addr];
    end
  end

  // Valid bits for the next links are cleared at once by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_vld <= '0;
    end else if (next_wr.we) begin
      next_vld[next_wr.addr] <= 1'b1;
    end
  end

  // An unwritten next link reads as the initial free chain slot + 1.
  assign rd.next   = vld_q ? next_q
                           : dstl_pkg::link_t'(addr_q) + dstl_pkg::link_t'(1);
  assign rd.prev   = prev_q;
  assign rd.kind   = kind_q;
  assign rd.number = number_q;
  assign rd.due    = due_q;

endmodule

FILE: sv/deadline_sorted_timer_list_core.sv
// Channel | handshake          | payload
// in      | in_valid, in_ready   | cmd, trigger_kind, trigger_number, due_time, now_time
// out     | out_valid, out_ready | status, out_kind, out_number, out_due, last
//
// One item is worked on at a time; all walks go through the single read port
// of the slot memory, one list entry per cycle.
// Insert walks past the entries before its place, the whole list when it goes last.
// Remove walks until a match, or over the whole list when none matches.
// Tick expires entries from the head until the head is live or the list is empty.
// Reset is synchronous; it empties the list and restores the free chain in slot order.
// A stalled output holds the block at its next result; a new item is taken once the
// final result of the previous one sits in the output register.
module deadline_sorted_timer_list_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dstl_pkg::CMD_W-1:0]         cmd,
  input  logic [dstl_pkg::KIND_W-1:0]        trigger_kind,
  input  logic [dstl_pkg::NUM_W-1:0]         trigger_number,
  input  logic [dstl_pkg::TIME_BITS-1:0]     due_time,
  input  logic [dstl_pkg::TIME_BITS-1:0]     now_time,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dstl_pkg::STATUS_W-1:0]      status,
  output logic [dstl_pkg::KIND_W-1:0]        out_kind,
  output logic [dstl_pkg::NUM_W-1:0]         out_number,
  output logic [dstl_pkg::TIME_BITS-1:0]     out_due,
  output logic                               last
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_POP,
    S_INS_WALK,
    S_INS_LINK,
    S_INS_FIX,
    S_RM_WALK,
    S_UNL_LINK,
    S_UNL_FREE,
    S_TK_HEAD,
    S_TK_CHK,
    S_RESP
  } state_t;

  state_t state;

  // List heads.
  dstl_pkg::link_t used_head;
  dstl_pkg::link_t free_head;

  // Latched item.
  dstl_pkg::kind_t  q_kind;
  dstl_pkg::num_t   q_number;
  dstl_pkg::stamp_t q_due;
  dstl_pkg::stamp_t q_now;

  // Walk and unlink context.
  dstl_pkg::idx_t  ins_slot;
  dstl_pkg::link_t cur;
  dstl_pkg::link_t prv;
  dstl_pkg::idx_t  unl_s;
  dstl_pkg::link_t unl_nx;
  dstl_pkg::link_t unl_pv;
  logic            unl_tick;

  // Result waiting to be sent.
  dstl_pkg::status_t res_status;
  dstl_pkg::kind_t   res_kind;
  dstl_pkg::num_t    res_number;
  dstl_pkg::stamp_t  res_due;
  logic              res_pend;

  // Memory ports.
  logic               rd_en;
  dstl_pkg::idx_t     rd_addr;
  dstl_pkg::link_wr_t next_wr;
  dstl_pkg::link_wr_t prev_wr;
  dstl_pkg::data_wr_t data_wr;
  dstl_pkg::slot_rd_t rd;

  logic out_free;
  logic expired;
  logic match;

  dstl_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .next_wr (next_wr),
    .prev_wr (prev_wr),
    .data_wr (data_wr),
    .rd      (rd)
  );

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign expired  = (rd.due <= q_now);
  assign match    = (rd.kind == q_kind) && (rd.number == q_number);

  // Memory reads and writes for each step.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    next_wr = '0;
    prev_wr = '0;
    data_wr = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && dstl_pkg::cmd_t'(cmd) == dstl_pkg::CMD_INSERT) begin
          rd_en   = 1'b1;
          rd_addr = free_head[dstl_pkg::IDX_W-1:0];
        end else if (in_valid && dstl_pkg::cmd_t'(cmd) == dstl_pkg::CMD_REMOVE) begin
          rd_en   = 1'b1;
          rd_addr = used_head[dstl_pkg::IDX_W-1:0];
        end
      end
      S_INS_POP: begin
        data_wr.we     = 1'b1;
        data_wr.addr   = ins_slot;
        data_wr.kind   = q_kind;
        data_wr.number = q_number;
        data_wr.due    = q_due;
        rd_en          = dstl_pkg::link_ok(used_head);
        rd_addr        = used_head[dstl_pkg::IDX_W-1:0];
      end
      S_INS_WALK: begin
        rd_en   = !(q_due <= rd.due) && dstl_pkg::link_ok(rd.next);
        rd_addr = rd.next[dstl_pkg::IDX_W-1:0];
      end
      S_INS_LINK: begin
        next_wr.we   = 1'b1;
        next_wr.addr = ins_slot;
        next_wr.data = cur;
        prev_wr.we   = dstl_pkg::link_ok(cur);
        prev_wr.addr = cur[dstl_pkg::IDX_W-1:0];
        prev_wr.data = dstl_pkg::link_t'(ins_slot);
      end
      S_INS_FIX: begin
        prev_wr.we   = 1'b1;
        prev_wr.addr = ins_slot;
        prev_wr.data = prv;
        next_wr.we   = dstl_pkg::link_ok(prv);
        next_wr.addr = prv[dstl_pkg::IDX_W-1:0];
        next_wr.data = dstl_pkg::link_t'(ins_slot);
      end
      S_RM_WALK: begin
        rd_en   = !match && dstl_pkg::link_ok(rd.next);
        rd_addr = rd.next[dstl_pkg::IDX_W-1:0];
      end
      S_UNL_LINK: begin
        prev_wr.we   = dstl_pkg::link_ok(unl_nx);
        prev_wr.addr = unl_nx[dstl_pkg::IDX_W-1:0];
        if (used_head == dstl_pkg::link_t'(unl_s)) begin
          prev_wr.data = dstl_pkg::NIL;
        end else begin
          prev_wr.data = unl_pv;
          next_wr.we   = dstl_pkg::link_ok(unl_pv);
          next_wr.addr = unl_pv[dstl_pkg::IDX_W-1:0];
          next_wr.data = unl_nx;
        end
      end
      S_UNL_FREE: begin
        next_wr.we   = 1'b1;
        next_wr.addr = unl_s;
        next_wr.data = free_head;
      end
      S_TK_HEAD: begin
        rd_en   = dstl_pkg::link_ok(used_head);
        rd_addr = used_head[dstl_pkg::IDX_W-1:0];
      end
      S_TK_CHK, S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // Sequencer, heads and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used_head <= dstl_pkg::NIL;
      free_head <= '0;
      res_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            q_kind   <= trigger_kind;
            q_number <= trigger_number;
            q_due    <= due_time;
            q_now    <= now_time;
            cur      <= used_head;
            res_pend <= 1'b0;
            unique case (dstl_pkg::cmd_t'(cmd))
              dstl_pkg::CMD_INSERT: begin
                res_kind   <= trigger_kind;
                res_number <= trigger_number;
                res_due    <= due_time;
                ins_slot   <= free_head[dstl_pkg::IDX_W-1:0];
                if (dstl_pkg::link_ok(free_head)) begin
                  res_status <= dstl_pkg::ST_INSERTED;
                  state      <= S_INS_POP;
                end else begin
                  res_status <= dstl_pkg::ST_POOL_FULL;
                  state      <= S_RESP;
                end
              end
              dstl_pkg::CMD_REMOVE: begin
                res_status <= dstl_pkg::ST_NOT_FOUND;
                res_kind   <= trigger_kind;
                res_number <= trigger_number;
                res_due    <= '0;
                state      <= dstl_pkg::link_ok(used_head) ? S_RM_WALK : S_RESP;
              end
              dstl_pkg::CMD_TICK: begin
                res_status <= dstl_pkg::ST_NONE_DUE;
                res_kind   <= '0;
                res_number <= '0;
                res_due    <= '0;
                state      <= S_TK_HEAD;
              end
              dstl_pkg::CMD_NOP: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        // Pop the free stack and start at the list head.
        S_INS_POP: begin
          free_head <= rd.next;
          cur       <= used_head;
          prv       <= dstl_pkg::NIL;
          state     <= dstl_pkg::link_ok(used_head) ? S_INS_WALK : S_INS_LINK;
        end
        // Stop at the first entry whose deadline is not below the new one.
        S_INS_WALK: begin
          if (q_due <= rd.due) begin
            state <= S_INS_LINK;
          end else begin
            prv <= cur;
            cur <= rd.next;
            if (!dstl_pkg::link_ok(rd.next)) begin
              state <= S_INS_LINK;
            end
          end
        end
        S_INS_LINK: begin
          state <= S_INS_FIX;
        end
        S_INS_FIX: begin
          if (!dstl_pkg::link_ok(prv)) begin
            used_head <= dstl_pkg::link_t'(ins_slot);
          end
          state <= S_RESP;
        end
        // Search by kind and index.
        S_RM_WALK: begin
          if (match) begin
            res_status <= dstl_pkg::ST_REMOVED;
            res_kind   <= rd.kind;
            res_number <= rd.number;
            res_due    <= rd.due;
            unl_s      <= cur[dstl_pkg::IDX_W-1:0];
            unl_nx     <= rd.next;
            unl_pv     <= rd.prev;
            unl_tick   <= 1'b0;
            state      <= S_UNL_LINK;
          end else if (dstl_pkg::link_ok(rd.next)) begin
            cur <= rd.next;
          end else begin
            state <= S_RESP;
          end
        end
        // Unlink a slot, then push it on the free stack.
        S_UNL_LINK: begin
          if (used_head == dstl_pkg::link_t'(unl_s)) begin
            used_head <= unl_nx;
          end
          state <= S_UNL_FREE;
        end
        S_UNL_FREE: begin
          free_head <= dstl_pkg::link_t'(unl_s);
          state     <= unl_tick ? S_TK_HEAD : S_RESP;
        end
        S_TK_HEAD: begin
          state <= dstl_pkg::link_ok(used_head) ? S_TK_CHK : S_RESP;
        end
        // An expired head sends the previous expiry, which is then not the final one.
        S_TK_CHK: begin
          if (expired) begin
            if (!res_pend || out_free) begin
              if (res_pend) begin
                out_valid  <= 1'b1;
                status     <= res_status;
                out_kind   <= res_kind;
                out_number <= res_number;
                out_due    <= res_due;
                last       <= 1'b0;
              end
              res_status <= dstl_pkg::ST_EXPIRED;
              res_kind   <= rd.kind;
              res_number <= rd.number;
              res_due    <= rd.due;
              res_pend   <= 1'b1;
              unl_s      <= used_head[dstl_pkg::IDX_W-1:0];
              unl_nx     <= rd.next;
              unl_pv     <= rd.prev;
              unl_tick   <= 1'b1;
              state      <= S_UNL_LINK;
            end
          end else begin
            state <= S_RESP;
          end
        end
        // Final result of the item.
        S_RESP: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            status     <= res_status;
            out_kind   <= res_kind;
            out_number <= res_number;
            out_due    <= res_due;
            last       <= 1'b1;
            res_pend   <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The used list and the free stack never start at the same slot.
  a_heads_apart: assert property (@(posedge clk) disable iff (rst)
    (dstl_pkg::link_ok(used_head) && dstl_pkg::link_ok(free_head))
      |-> (used_head != free_head))
    else $error("used and free heads point at the same slot");

  // Reads never overlap a link write, so no forwarding is needed.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (!next_wr.we && !prev_wr.we))
    else $error("slot read overlaps a link write");

  // A non-final result is always followed by a pending expiry.
  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> res_pend)
    else $error("non-final result without a following expiry");

  // No expiry is left pending between items.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !res_pend)
    else $error("expiry left pending at idle");

endmodule

FILE: dv/deadline_sorted_timer_list_core_test.sv
module deadline_sorted_timer_list_core_test;

  localparam int MAX_OUT     = 32;
  localparam int RAND_ITEMS  = 64;
  localparam int SETTLE      = 100;
  localparam int CYCLE_LIMIT = 400000;
  localparam dstl_pkg::stamp_t ALL_ONES = '1;

  // One result item as the checker sees it.
  typedef struct packed {
    dstl_pkg::status_t status;
    dstl_pkg::kind_t   kind;
    dstl_pkg::num_t    number;
    dstl_pkg::stamp_t  due;
    logic              last;
  } timer_result_t;

  logic                                clk;
  logic                                rst;
  logic                                in_valid;
  logic                                in_ready;
  logic [dstl_pkg::CMD_W-1:0]          cmd;
  logic [dstl_pkg::KIND_W-1:0]         trigger_kind;
  logic [dstl_pkg::NUM_W-1:0]          trigger_number;
  logic [dstl_pkg::TIME_BITS-1:0]      due_time;
  logic [dstl_pkg::TIME_BITS-1:0]      now_time;
  logic                                out_valid;
  logic                                out_ready;
  logic [dstl_pkg::STATUS_W-1:0]       status;
  logic [dstl_pkg::KIND_W-1:0]         out_kind;
  logic [dstl_pkg::NUM_W-1:0]          out_number;
  logic [dstl_pkg::TIME_BITS-1:0]      out_due;
  logic                                last;

  // Shadow copy of the timer pool.
  dstl_pkg::link_t  succ_link[dstl_pkg::SLOT_COUNT];
  dstl_pkg::link_t  pred_link[dstl_pkg::SLOT_COUNT];
  dstl_pkg::stamp_t slot_deadline[dstl_pkg::SLOT_COUNT];
  dstl_pkg::kind_t  slot_owner_kind[dstl_pkg::SLOT_COUNT];
  dstl_pkg::num_t   slot_owner_num[dstl_pkg::SLOT_COUNT];
  dstl_pkg::link_t  list_head;
  dstl_pkg::link_t  free_top;

  timer_result_t    expected_results[$];
  int               errors;
  int               cycle_count;
  int               ready_stall;
  bit               calm;
  dstl_pkg::stamp_t clock_now;

  deadline_sorted_timer_list_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .trigger_kind   (trigger_kind),
    .trigger_number (trigger_number),
    .due_time       (due_time),
    .now_time       (now_time),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .out_kind       (out_kind),
    .out_number     (out_number),
    .out_due        (out_due),
    .last           (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle lengths: mostly none or short, now and then long.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // Put the shadow pool into its post-reset state.
  function void clear_timer_pool();
    for (int i = 0; i < dstl_pkg::SLOT_COUNT; i++) begin
      succ_link[i] = dstl_pkg::link_t'(i + 1);
    end
    list_head = dstl_pkg::NIL;
    free_top  = '0;
  endfunction

  function void queue_result(dstl_pkg::status_t st, dstl_pkg::kind_t k, dstl_pkg::num_t n,
                             dstl_pkg::stamp_t d, logic fin);
    timer_result_t r;
    r.status = st;
    r.kind   = k;
    r.number = n;
    r.due    = d;
    r.last   = fin;
    expected_results.push_back(r);
  endfunction

  // Take a listed slot out of the list and push it on the free stack.
  function void detach_slot(dstl_pkg::link_t s);
    dstl_pkg::link_t nx;
    dstl_pkg::link_t pv;
    nx = succ_link[s];
    pv = pred_link[s];
    if (list_head == s) begin
      if (nx < dstl_pkg::NIL) pred_link[nx] = dstl_pkg::NIL;
      list_head = nx;
    end else begin
      if (nx < dstl_pkg::NIL) pred_link[nx] = pv;
      if (pv < dstl_pkg::NIL) succ_link[pv] = nx;
    end
    succ_link[s] = free_top;
    free_top = s;
  endfunction

  // Apply one accepted item to the shadow pool and queue its results.
  function void predict_timer_list(dstl_pkg::cmd_t c, dstl_pkg::kind_t k, dstl_pkg::num_t n,
                                   dstl_pkg::stamp_t d, dstl_pkg::stamp_t now);
    dstl_pkg::link_t s;
    dstl_pkg::link_t cur;
    dstl_pkg::link_t prv;
    int              guard;
    int              count;
    bit              found;
    bit              more;
    timer_result_t   r;
    case (c)
      dstl_pkg::CMD_INSERT: begin
        if (!(free_top < dstl_pkg::NIL)) begin
          queue_result(dstl_pkg::ST_POOL_FULL, k, n, d, 1'b1);
        end else begin
          s = free_top;
          free_top = succ_link[s];
          slot_owner_kind[s] = k;
          slot_owner_num[s]  = n;
          slot_deadline[s]   = d;
          // Stop at the first entry whose deadline is not below the new one.
          cur = list_head;
          prv = dstl_pkg::NIL;
          guard = 0;
          while (cur < dstl_pkg::NIL && guard < dstl_pkg::SLOT_COUNT &&
                 d > slot_deadline[cur]) begin
            prv = cur;
            cur = succ_link[cur];
            guard++;
          end
          if (!(cur < dstl_pkg::NIL)) cur = dstl_pkg::NIL;
          succ_link[s] = cur;
          pred_link[s] = prv;
          if (prv < dstl_pkg::NIL) succ_link[prv] = s;
          else list_head = s;
          if (cur < dstl_pkg::NIL) pred_link[cur] = s;
          queue_result(dstl_pkg::ST_INSERTED, k, n, d, 1'b1);
        end
      end
      dstl_pkg::CMD_REMOVE: begin
        cur = list_head;
        guard = 0;
        found = 1'b0;
        while (!found && cur < dstl_pkg::NIL && guard < dstl_pkg::SLOT_COUNT) begin
          if (slot_owner_kind[cur] == k && slot_owner_num[cur] == n) found = 1'b1;
          else cur = succ_link[cur];
          guard++;
        end
        if (found) begin
          queue_result(dstl_pkg::ST_REMOVED, slot_owner_kind[cur], slot_owner_num[cur],
                       slot_deadline[cur], 1'b1);
          detach_slot(cur);
        end else begin
          queue_result(dstl_pkg::ST_NOT_FOUND, k, n, '0, 1'b1);
        end
      end
      dstl_pkg::CMD_TICK: begin
        count = 0;
        while (count < MAX_OUT && list_head < dstl_pkg::NIL &&
               slot_deadline[list_head] <= now) begin
          s = list_head;
          r.status = dstl_pkg::ST_EXPIRED;
          r.kind   = slot_owner_kind[s];
          r.number = slot_owner_num[s];
          r.due    = slot_deadline[s];
          count++;
          detach_slot(s);
          more = count < MAX_OUT && list_head < dstl_pkg::NIL &&
                 slot_deadline[list_head] <= now;
          r.last = !more;
          expected_results.push_back(r);
        end
        if (count == 0) queue_result(dstl_pkg::ST_NONE_DUE, '0, '0, '0, 1'b1);
      end
      default: begin
      end
    endcase
  endfunction

  // Choose a random entry that is currently on the list.
  function bit pick_listed(output dstl_pkg::kind_t k, output dstl_pkg::num_t n);
    dstl_pkg::link_t cur;
    int              count;
    int              pos;
    k = '0;
    n = '0;
    count = 0;
    cur = list_head;
    while (cur < dstl_pkg::NIL && count < dstl_pkg::SLOT_COUNT) begin
      count++;
      cur = succ_link[cur];
    end
    if (count == 0) return 1'b0;
    pos = $urandom_range(0, count - 1);
    cur = list_head;
    for (int i = 0; i < pos; i++) cur = succ_link[cur];
    k = slot_owner_kind[cur];
    n = slot_owner_num[cur];
    return 1'b1;
  endfunction

  // Offer one item, wait for its acceptance, then idle for a random while, if at all.
  task automatic send_item(dstl_pkg::cmd_t c, dstl_pkg::kind_t k, dstl_pkg::num_t n,
                           dstl_pkg::stamp_t d, dstl_pkg::stamp_t now);
    int gap;
    in_valid       <= 1'b1;
    cmd            <= c;
    trigger_kind   <= k;
    trigger_number <= n;
    due_time       <= d;
    now_time       <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_timer_list(c, k, n, d, now);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic insert_timer(dstl_pkg::kind_t k, dstl_pkg::num_t n, dstl_pkg::stamp_t d);
    send_item(dstl_pkg::CMD_INSERT, k, n, d, dstl_pkg::stamp_t'($urandom));
  endtask

  task automatic remove_timer(dstl_pkg::kind_t k, dstl_pkg::num_t n);
    send_item(dstl_pkg::CMD_REMOVE, k, n, dstl_pkg::stamp_t'($urandom),
              dstl_pkg::stamp_t'($urandom));
  endtask

  task automatic tick_at(dstl_pkg::stamp_t now);
    send_item(dstl_pkg::CMD_TICK, dstl_pkg::kind_t'($urandom), dstl_pkg::num_t'($urandom),
              dstl_pkg::stamp_t'($urandom), now);
  endtask

  // Hold off the input until every queued result has come out.
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Ticks and removes on an empty list.
  task automatic test_empty_list();
    tick_at('0);
    remove_timer(2'd1, 5'd3);
  endtask

  // Inserts at the deadline extremes, equal deadlines and out-of-order arrivals, then a NOP and ticks.
  task automatic test_sorted_insert();
    insert_timer(2'd0, 5'd0, '0);
    insert_timer(2'd2, 5'd31, ALL_ONES);
    insert_timer(2'd3, 5'd17, 32'd100);
    insert_timer(2'd1, 5'd5, 32'd100);
    insert_timer(2'd1, 5'd6, 32'd100);
    insert_timer(2'd0, 5'd9, 32'd50);
    insert_timer(2'd0, 5'd10, 32'd40);
    send_item(dstl_pkg::CMD_NOP, 2'd3, 5'd31, ALL_ONES, ALL_ONES);
    tick_at('0);
    tick_at(32'd99);
    tick_at(32'd99);
  endtask

  // Removal by kind and index, including kind three and a repeated removal.
  task automatic test_remove_by_id();
    remove_timer(2'd3, 5'd17);
    remove_timer(2'd3, 5'd17);
    remove_timer(2'd2, 5'd31);
    insert_timer(2'd2, 5'd31, ALL_ONES);
    insert_timer(2'd0, 5'd31, 32'd7);
    remove_timer(2'd0, 5'd31);
  endtask

  // Ticks that expire several entries, up to the largest time.
  task automatic test_tick_extremes();
    tick_at(32'd100);
    tick_at(ALL_ONES);
  endtask

  // Fill the pool with no idling, overflow it, then expire every entry at once.
  task automatic test_pool_full();
    dstl_pkg::kind_t k;
    dstl_pkg::num_t  n;
    calm = 1'b1;
    for (int i = 0; i < dstl_pkg::SLOT_COUNT; i++) begin
      insert_timer(dstl_pkg::kind_t'($urandom_range(0, 3)),
                   dstl_pkg::num_t'($urandom_range(0, 7)),
                   ($urandom_range(0, 3) == 0) ? dstl_pkg::stamp_t'($urandom)
                                               : dstl_pkg::stamp_t'($urandom_range(0, 20)));
    end
    insert_timer(2'd2, 5'd30, 32'd5);
    insert_timer(2'd1, 5'd1, ALL_ONES);
    if (pick_listed(k, n)) remove_timer(k, n);
    insert_timer(2'd0, 5'd12, 32'd3);
    tick_at(ALL_ONES);
    calm = 1'b0;
    wait_until_drained();
  endtask

  // Mixed traffic, mostly on live entries, with a full drain in the middle.
  task automatic test_random();
    dstl_pkg::kind_t  k;
    dstl_pkg::num_t   n;
    dstl_pkg::stamp_t d;
    int               r;
    clock_now = 32'd1000;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 2) wait_until_drained();
      r = $urandom_range(0, 99);
      if (r < 45) begin
        k = ($urandom_range(0, 9) == 0) ? 2'd3 : dstl_pkg::kind_t'($urandom_range(0, 2));
        n = ($urandom_range(0, 2) == 0) ? dstl_pkg::num_t'($urandom_range(0, 3))
                                        : dstl_pkg::num_t'($urandom_range(0, 31));
        d = ($urandom_range(0, 9) == 0)
              ? dstl_pkg::stamp_t'($urandom)
              : clock_now + dstl_pkg::stamp_t'($urandom_range(0, 150));
        insert_timer(k, n, d);
      end else if (r < 70) begin
        if ($urandom_range(0, 3) == 0 || !pick_listed(k, n)) begin
          k = dstl_pkg::kind_t'($urandom_range(0, 3));
          n = dstl_pkg::num_t'($urandom_range(0, 31));
        end
        remove_timer(k, n);
      end else if (r < 96) begin
        if ($urandom_range(0, 19) == 0) begin
          tick_at(($urandom_range(0, 1) == 0) ? ALL_ONES : dstl_pkg::stamp_t'($urandom));
        end else begin
          clock_now = clock_now + dstl_pkg::stamp_t'($urandom_range(0, 80));
          tick_at(clock_now);
        end
      end else begin
        send_item(dstl_pkg::CMD_NOP, dstl_pkg::kind_t'($urandom), dstl_pkg::num_t'($urandom),
                  dstl_pkg::stamp_t'($urandom), dstl_pkg::stamp_t'($urandom));
      end
    end
  endtask

  // Output side: random stalls except during calm stretches.
  always @(posedge clk) begin
    if (ready_stall > 0) begin
      ready_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) ready_stall = pick_gap();
    end
  end

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    timer_result_t got;
    timer_result_t want;
    if (!rst && out_valid && out_ready) begin
      got.status = dstl_pkg::status_t'(status);
      got.kind   = out_kind;
      got.number = out_number;
      got.due    = out_due;
      got.last   = last;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d kind=%0d number=%0d due=%h last=%0b",
                 $time, got.status, got.kind, got.number, got.due, got.last);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected status=%0d kind=%0d number=%0d due=%h last=%0b",
                   $time, want.status, want.kind, want.number, want.due, want.last);
          $display("%0t:          actual   status=%0d kind=%0d number=%0d due=%h last=%0b",
                   $time, got.status, got.kind, got.number, got.due, got.last);
          errors++;
        end
      end
    end
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    cmd            = '0;
    trigger_kind   = '0;
    trigger_number = '0;
    due_time       = '0;
    now_time       = '0;
    calm           = 1'b0;
    clock_now      = '0;
    clear_timer_pool();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_empty_list();
    test_sorted_insert();
    test_remove_by_id();
    test_tick_extremes();
    test_pool_full();
    test_random();

    // Let the last results out and give the block time to show any stray ones.
    wait_until_drained();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
